// ----- design/tsm_pkg.sv -----
// Shared types and constants for the two-wire sensor master.
package tsm_pkg;

	// Sequencer phases, one per half-bit action
	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_RST_HI   = 5'd1,
		PH_RST_LO   = 5'd2,
		PH_ST0      = 5'd3,
		PH_ST1      = 5'd4,
		PH_ST2      = 5'd5,
		PH_ST3      = 5'd6,
		PH_ST4      = 5'd7,
		PH_TX_LOW   = 5'd8,
		PH_TX_DATA  = 5'd9,
		PH_TX_CLK   = 5'd10,
		PH_ACK_REL  = 5'd11,
		PH_ACK_POLL = 5'd12,
		PH_ACK_END  = 5'd13,
		PH_WAIT     = 5'd14,
		PH_READY    = 5'd15,
		PH_RX_LOW   = 5'd16,
		PH_RX_HI    = 5'd17,
		PH_RX_FALL  = 5'd18,
		PH_MA0      = 5'd19,
		PH_MA1      = 5'd20,
		PH_MA2      = 5'd21,
		PH_MA3      = 5'd22,
		PH_END0     = 5'd23,
		PH_END1     = 5'd24
	} phase_t;

	// Operation codes
	typedef enum logic [1:0] {
		OP_MEASURE  = 2'd0,
		OP_READ_SR  = 2'd1,
		OP_WRITE_SR = 2'd2,
		OP_CONN_RST = 2'd3
	} op_t;

	// Request kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// Configuration register indexes
	localparam logic REG_TIMEOUT      = 1'b0;
	localparam logic REG_TICKS_PER_MS = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET      = 16'd255;
	localparam logic [15:0] TICKS_PER_MS_RESET = 16'd100;

	localparam logic [3:0]  RESET_CLOCKS  = 4'd9;
	localparam logic [3:0]  BYTE_BITS     = 4'd8;
	localparam logic [15:0] READ_FAIL_VAL = 16'h00ff;

	// One input request
	typedef struct packed {
		logic       kind;
		op_t        operation;
		logic [7:0] command_byte;
		logic [7:0] write_byte;
		logic [7:0] wait_time;
		logic       data_pin;
	} item_t;

	// One result
	typedef struct packed {
		logic        sck;
		logic        data_release;
		logic        busy_res;
		logic        done_res;
		logic [15:0] result_value;
		logic        status;
	} result_t;

endpackage

// ----- design/tsm_seq.sv -----
// Pin sequencer: state registers and per-request next-state logic.
module tsm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  tsm_pkg::item_t  item,
	input  logic [15:0]     timeout_limit,
	input  logic [15:0]     ticks_per_ms,
	output tsm_pkg::result_t res
);

	tsm_pkg::phase_t phase_q, phase_d;
	logic [3:0]  bit_index_q, bit_index_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] poll_q, poll_d;
	logic [23:0] wait_q, wait_d;
	logic [7:0]  high_q, high_d;
	tsm_pkg::op_t pend_op_q, pend_op_d;
	logic [7:0]  pend_cmd_q, pend_cmd_d;
	logic [7:0]  pend_wr_q, pend_wr_d;
	logic [7:0]  pend_wait_q, pend_wait_d;
	logic        stage_q, stage_d;
	logic        sck_q, sck_d;
	logic        data_q, data_d;
	logic [15:0] held_value_q, held_value_d;
	logic        held_status_q, held_status_d;
	logic        done_q, done_d;

	logic [23:0] total;
	logic [3:0]  bit_inc;
	logic        poll_expired;
	logic        is_start;

	assign total        = 24'(pend_wait_q) * 24'(ticks_per_ms);
	assign bit_inc      = bit_index_q + 4'd1;
	assign poll_expired = (poll_q == timeout_limit);
	assign is_start     = (item.kind == tsm_pkg::KIND_START);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			if (phase_q == tsm_pkg::PH_IDLE) begin
				phase_d = (item.operation == tsm_pkg::OP_CONN_RST) ?
					tsm_pkg::PH_RST_HI : tsm_pkg::PH_ST0;
			end
		end else begin
			case (phase_q)
				tsm_pkg::PH_IDLE:    phase_d = tsm_pkg::PH_IDLE;
				tsm_pkg::PH_RST_HI:  phase_d = tsm_pkg::PH_RST_LO;
				tsm_pkg::PH_RST_LO:  phase_d = (bit_inc >= tsm_pkg::RESET_CLOCKS) ?
					tsm_pkg::PH_ST0 : tsm_pkg::PH_RST_HI;
				tsm_pkg::PH_ST0:     phase_d = tsm_pkg::PH_ST1;
				tsm_pkg::PH_ST1:     phase_d = tsm_pkg::PH_ST2;
				tsm_pkg::PH_ST2:     phase_d = tsm_pkg::PH_ST3;
				tsm_pkg::PH_ST3:     phase_d = tsm_pkg::PH_ST4;
				tsm_pkg::PH_ST4:     phase_d = (pend_op_q == tsm_pkg::OP_CONN_RST) ?
					tsm_pkg::PH_IDLE : tsm_pkg::PH_TX_LOW;
				tsm_pkg::PH_TX_LOW:  phase_d = tsm_pkg::PH_TX_DATA;
				tsm_pkg::PH_TX_DATA: phase_d = tsm_pkg::PH_TX_CLK;
				tsm_pkg::PH_TX_CLK:  phase_d = (bit_inc >= tsm_pkg::BYTE_BITS) ?
					tsm_pkg::PH_ACK_REL : tsm_pkg::PH_TX_DATA;
				tsm_pkg::PH_ACK_REL: phase_d = tsm_pkg::PH_ACK_POLL;
				tsm_pkg::PH_ACK_POLL: begin
					if (!item.data_pin) phase_d = tsm_pkg::PH_ACK_END;
					else if (poll_expired) phase_d = tsm_pkg::PH_IDLE;
				end
				tsm_pkg::PH_ACK_END: begin
					case (pend_op_q)
						tsm_pkg::OP_MEASURE: phase_d = (total == 24'd0) ?
							tsm_pkg::PH_READY : tsm_pkg::PH_WAIT;
						tsm_pkg::OP_READ_SR: phase_d = tsm_pkg::PH_RX_LOW;
						tsm_pkg::OP_WRITE_SR: phase_d = stage_q ?
							tsm_pkg::PH_IDLE : tsm_pkg::PH_TX_LOW;
						default: phase_d = tsm_pkg::PH_IDLE;
					endcase
				end
				tsm_pkg::PH_WAIT: begin
					if (wait_q == 24'd1) phase_d = tsm_pkg::PH_READY;
				end
				tsm_pkg::PH_READY: begin
					if (!item.data_pin) phase_d = tsm_pkg::PH_RX_LOW;
					else if (poll_expired) phase_d = tsm_pkg::PH_IDLE;
				end
				tsm_pkg::PH_RX_LOW:  phase_d = tsm_pkg::PH_RX_HI;
				tsm_pkg::PH_RX_HI:   phase_d = tsm_pkg::PH_RX_FALL;
				tsm_pkg::PH_RX_FALL: begin
					if (bit_inc < tsm_pkg::BYTE_BITS) phase_d = tsm_pkg::PH_RX_HI;
					else if (pend_op_q == tsm_pkg::OP_MEASURE && !stage_q)
						phase_d = tsm_pkg::PH_MA0;
					else phase_d = tsm_pkg::PH_END0;
				end
				tsm_pkg::PH_MA0:     phase_d = tsm_pkg::PH_MA1;
				tsm_pkg::PH_MA1:     phase_d = tsm_pkg::PH_MA2;
				tsm_pkg::PH_MA2:     phase_d = tsm_pkg::PH_MA3;
				tsm_pkg::PH_MA3:     phase_d = tsm_pkg::PH_RX_LOW;
				tsm_pkg::PH_END0:    phase_d = tsm_pkg::PH_END1;
				tsm_pkg::PH_END1:    phase_d = tsm_pkg::PH_IDLE;
				default:             phase_d = tsm_pkg::PH_IDLE;
			endcase
		end
	end

	// Datapath, pin levels and finish outputs
	always_comb begin
		bit_index_d   = bit_index_q;
		shift_d       = shift_q;
		poll_d        = poll_q;
		wait_d        = wait_q;
		high_d        = high_q;
		pend_op_d     = pend_op_q;
		pend_cmd_d    = pend_cmd_q;
		pend_wr_d     = pend_wr_q;
		pend_wait_d   = pend_wait_q;
		stage_d       = stage_q;
		sck_d         = sck_q;
		data_d        = data_q;
		held_value_d  = held_value_q;
		held_status_d = held_status_q;
		done_d        = 1'b0;
		if (is_start) begin
			// Latch a new operation only when idle
			if (phase_q == tsm_pkg::PH_IDLE) begin
				pend_op_d   = item.operation;
				pend_cmd_d  = item.command_byte;
				pend_wr_d   = item.write_byte;
				pend_wait_d = item.wait_time;
				stage_d     = 1'b0;
				bit_index_d = 4'd0;
				poll_d      = 16'd0;
			end
		end else begin
			case (phase_q)
				tsm_pkg::PH_RST_HI: begin
					sck_d  = 1'b1;
					data_d = 1'b1;
				end
				tsm_pkg::PH_RST_LO: begin
					sck_d       = 1'b0;
					bit_index_d = (bit_inc >= tsm_pkg::RESET_CLOCKS) ? 4'd0 : bit_inc;
				end
				tsm_pkg::PH_ST0: begin
					sck_d  = 1'b1;
					data_d = 1'b1;
				end
				tsm_pkg::PH_ST1: data_d = 1'b0;
				tsm_pkg::PH_ST2: sck_d = 1'b0;
				tsm_pkg::PH_ST3: sck_d = 1'b1;
				tsm_pkg::PH_ST4: begin
					data_d = 1'b1;
					if (pend_op_q == tsm_pkg::OP_CONN_RST) begin
						held_value_d  = 16'd0;
						held_status_d = 1'b0;
						done_d        = 1'b1;
					end else begin
						shift_d     = pend_cmd_q;
						bit_index_d = 4'd0;
						stage_d     = 1'b0;
					end
				end
				tsm_pkg::PH_TX_LOW: sck_d = 1'b0;
				tsm_pkg::PH_TX_DATA: begin
					sck_d   = 1'b0;
					data_d  = shift_q[7];
					shift_d = {shift_q[6:0], 1'b0};
				end
				tsm_pkg::PH_TX_CLK: begin
					sck_d       = 1'b1;
					bit_index_d = (bit_inc >= tsm_pkg::BYTE_BITS) ? 4'd0 : bit_inc;
				end
				tsm_pkg::PH_ACK_REL: begin
					sck_d  = 1'b0;
					data_d = 1'b1;
					poll_d = 16'd0;
				end
				tsm_pkg::PH_ACK_POLL: begin
					sck_d  = 1'b1;
					data_d = 1'b1;
					if (item.data_pin) begin
						if (poll_expired) begin
							held_value_d  = (pend_op_q == tsm_pkg::OP_READ_SR) ?
								tsm_pkg::READ_FAIL_VAL : 16'd0;
							held_status_d = 1'b1;
							done_d        = 1'b1;
						end else begin
							poll_d = poll_q + 16'd1;
						end
					end
				end
				tsm_pkg::PH_ACK_END: begin
					sck_d  = 1'b0;
					data_d = 1'b1;
					case (pend_op_q)
						tsm_pkg::OP_MEASURE: begin
							poll_d = 16'd0;
							if (total != 24'd0) wait_d = total;
						end
						tsm_pkg::OP_READ_SR: begin
							stage_d     = 1'b0;
							bit_index_d = 4'd0;
						end
						tsm_pkg::OP_WRITE_SR: begin
							if (!stage_q) begin
								stage_d     = 1'b1;
								shift_d     = pend_wr_q;
								bit_index_d = 4'd0;
							end else begin
								held_value_d  = 16'd0;
								held_status_d = 1'b0;
								done_d        = 1'b1;
							end
						end
						default: begin
							held_value_d  = 16'd0;
							held_status_d = 1'b0;
							done_d        = 1'b1;
						end
					endcase
				end
				tsm_pkg::PH_WAIT: begin
					wait_d = wait_q - 24'd1;
					if (wait_q == 24'd1) poll_d = 16'd0;
				end
				tsm_pkg::PH_READY: begin
					if (!item.data_pin) begin
						bit_index_d = 4'd0;
						stage_d     = 1'b0;
					end else if (poll_expired) begin
						held_value_d  = 16'd0;
						held_status_d = 1'b1;
						done_d        = 1'b1;
					end else begin
						poll_d = poll_q + 16'd1;
					end
				end
				tsm_pkg::PH_RX_LOW: begin
					sck_d  = 1'b0;
					data_d = 1'b1;
				end
				tsm_pkg::PH_RX_HI: begin
					sck_d   = 1'b1;
					shift_d = {shift_q[6:0], item.data_pin};
				end
				tsm_pkg::PH_RX_FALL: begin
					sck_d = 1'b0;
					if (bit_inc < tsm_pkg::BYTE_BITS) begin
						bit_index_d = bit_inc;
					end else begin
						bit_index_d = 4'd0;
						if (pend_op_q == tsm_pkg::OP_MEASURE && !stage_q) begin
							high_d  = shift_q;
							stage_d = 1'b1;
						end
					end
				end
				tsm_pkg::PH_MA0: sck_d = 1'b0;
				tsm_pkg::PH_MA1: data_d = 1'b0;
				tsm_pkg::PH_MA2: sck_d = 1'b1;
				tsm_pkg::PH_MA3: sck_d = 1'b0;
				tsm_pkg::PH_END0: begin
					data_d = 1'b1;
					sck_d  = 1'b1;
				end
				tsm_pkg::PH_END1: begin
					sck_d         = 1'b0;
					held_value_d  = (pend_op_q == tsm_pkg::OP_MEASURE) ?
						{high_q, shift_q} : {8'd0, shift_q};
					held_status_d = 1'b0;
					done_d        = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Advance state once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tsm_pkg::PH_IDLE;
			bit_index_q   <= 4'd0;
			shift_q       <= 8'd0;
			poll_q        <= 16'd0;
			wait_q        <= 24'd0;
			high_q        <= 8'd0;
			pend_op_q     <= tsm_pkg::OP_MEASURE;
			pend_cmd_q    <= 8'd0;
			pend_wr_q     <= 8'd0;
			pend_wait_q   <= 8'd0;
			stage_q       <= 1'b0;
			sck_q         <= 1'b0;
			data_q        <= 1'b1;
			held_value_q  <= 16'd0;
			held_status_q <= 1'b0;
			done_q        <= 1'b0;
		end else if (step_en) begin
			phase_q       <= phase_d;
			bit_index_q   <= bit_index_d;
			shift_q       <= shift_d;
			poll_q        <= poll_d;
			wait_q        <= wait_d;
			high_q        <= high_d;
			pend_op_q     <= pend_op_d;
			pend_cmd_q    <= pend_cmd_d;
			pend_wr_q     <= pend_wr_d;
			pend_wait_q   <= pend_wait_d;
			stage_q       <= stage_d;
			sck_q         <= sck_d;
			data_q        <= data_d;
			held_value_q  <= held_value_d;
			held_status_q <= held_status_d;
			done_q        <= done_d;
		end
	end

	// Present the registered result
	always_comb begin
		res.sck          = sck_q;
		res.data_release = data_q;
		res.busy_res     = (phase_q != tsm_pkg::PH_IDLE);
		res.done_res     = done_q;
		res.result_value = held_value_q;
		res.status       = held_status_q;
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == tsm_pkg::PH_IDLE)
		else $error("done flagged while sequencer busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(held_value_q) && $stable(done_q))
		else $error("state moved without a request");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && is_start && phase_q == tsm_pkg::PH_IDLE |=>
			phase_q == tsm_pkg::PH_RST_HI || phase_q == tsm_pkg::PH_ST0)
		else $error("start from idle did not launch an operation");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= tsm_pkg::RESET_CLOCKS)
		else $error("bit counter out of range");

endmodule

// ----- design/two_wire_sensor_master.sv -----
// Two-wire humidity sensor master: top level with request and result registers.
//
// Requests arrive on the in_valid/in_ready channel: kind 1 starts an operation
// (measure, read status, write status, connection reset), kind 0 is one half-bit
// time tick on which the sequencer drives sck and the data line and samples
// data_pin. Every request yields exactly one result on out_valid/out_ready
// carrying the pin levels, busy/done flags and the last finished value/status.
// A request is held in an input register, then one pass of the sequencer logic
// updates the state and result registers and raises out_valid, and one request
// is taken every cycle while results drain.
// If the receiver stalls, the finished result holds, one more request waits in
// the input register, and in_ready drops until the result is taken.
// The cfg channel, always ready, writes timeout_limit (index 0) and ticks_per_ms
// (index 1); the user must use it while the block is idle (not enforced).
// Reset clears both channels, returns the sequencer to idle with sck low and
// data released, and loads timeout_limit 255 and ticks_per_ms 100.
module two_wire_sensor_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [1:0]  operation,
	input  logic [7:0]  command_byte,
	input  logic [7:0]  write_byte,
	input  logic [7:0]  wait_time,
	input  logic        data_pin,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sck,
	output logic        data_release,
	output logic        busy_res,
	output logic        done_res,
	output logic [15:0] result_value,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	tsm_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic             step;
	logic [15:0]      timeout_q;
	logic [15:0]      tpm_q;
	tsm_pkg::result_t res;

	assign step      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	// Capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind         <= kind;
			item_s1.operation    <= tsm_pkg::op_t'(operation);
			item_s1.command_byte <= command_byte;
			item_s1.write_byte   <= write_byte;
			item_s1.wait_time    <= wait_time;
			item_s1.data_pin     <= data_pin;
		end
	end

	// Track result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tsm_pkg::TIMEOUT_RESET;
			tpm_q     <= tsm_pkg::TICKS_PER_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsm_pkg::REG_TIMEOUT:      timeout_q <= cfg_data;
				tsm_pkg::REG_TICKS_PER_MS: tpm_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	tsm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step),
		.item          (item_s1),
		.timeout_limit (timeout_q),
		.ticks_per_ms  (tpm_q),
		.res           (res)
	);

	assign out_valid    = out_valid_q;
	assign sck          = res.sck;
	assign data_release = res.data_release;
	assign busy_res     = res.busy_res;
	assign done_res     = res.done_res;
	assign result_value = res.result_value;
	assign status       = res.status;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(result_value) && $stable(sck))
		else $error("stalled result changed");

	a_no_step_full: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !out_valid_q || out_ready)
		else $error("result overwritten before it was taken");

endmodule

// ----- tb/sensor_master_checker.sv -----
// Result checker for the two-wire sensor master: predicts every result and compares it.
module sensor_master_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic [1:0]  operation,
	input  logic [7:0]  command_byte,
	input  logic [7:0]  write_byte,
	input  logic [7:0]  wait_time,
	input  logic        data_pin,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        sck,
	input  logic        data_release,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [15:0] result_value,
	input  logic        status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted sequencer state
	tsm_pkg::phase_t seq_phase;
	logic [3:0]      bit_idx;
	logic [7:0]      shift_q;
	logic [15:0]     poll_cnt;
	logic [23:0]     wait_cnt;
	logic [7:0]      hi_byte;
	tsm_pkg::op_t    op_q;
	logic [7:0]      cmd_q;
	logic [7:0]      wr_q;
	logic [7:0]      wait_q;
	logic            stage_q;
	logic            sck_q;
	logic            dat_q;
	logic            done_q;
	logic            held_st;
	logic [15:0]     held_val;

	// Predicted register contents
	logic [15:0] timeout_lim;
	logic [15:0] ticks_ms;

	// Pin levels and results still owed by the block, oldest first
	tsm_pkg::result_t pin_results_q[$];
	tsm_pkg::result_t want;
	tsm_pkg::result_t got;
	tsm_pkg::item_t   req;

	// Print the first 40 mismatches, count all of them
	task automatic flag_mismatch(input string what, input int unsigned seen,
			input int unsigned owed);
		fail_count++;
		if (fail_count <= 40) begin
			$display("t=%0t: mismatch on %s: got %0h, want %0h", $time, what, seen, owed);
		end
	endtask

	// Close the running operation and hold its value and status
	task automatic finish_op(input logic [15:0] value, input logic st);
		seq_phase = tsm_pkg::PH_IDLE;
		held_val  = value;
		held_st   = st;
		done_q    = 1'b1;
	endtask

	// Apply one request to the predicted state and return the pin levels after it
	task automatic advance_sequencer(input tsm_pkg::item_t r, output tsm_pkg::result_t res);
		logic [23:0] total;
		done_q = 1'b0;
		if (r.kind == tsm_pkg::KIND_START) begin
			// latch a new operation only while idle, without spending a tick
			if (seq_phase == tsm_pkg::PH_IDLE) begin
				op_q      = r.operation;
				cmd_q     = r.command_byte;
				wr_q      = r.write_byte;
				wait_q    = r.wait_time;
				stage_q   = 1'b0;
				bit_idx   = '0;
				poll_cnt  = '0;
				seq_phase = (r.operation == tsm_pkg::OP_CONN_RST) ?
					tsm_pkg::PH_RST_HI : tsm_pkg::PH_ST0;
			end
		end else begin
			case (seq_phase)
				tsm_pkg::PH_RST_HI: begin
					sck_q = 1'b1; dat_q = 1'b1; seq_phase = tsm_pkg::PH_RST_LO;
				end
				tsm_pkg::PH_RST_LO: begin
					sck_q   = 1'b0;
					bit_idx = bit_idx + 4'd1;
					if (bit_idx >= tsm_pkg::RESET_CLOCKS) begin
						bit_idx = '0; seq_phase = tsm_pkg::PH_ST0;
					end else begin
						seq_phase = tsm_pkg::PH_RST_HI;
					end
				end
				tsm_pkg::PH_ST0: begin
					sck_q = 1'b1; dat_q = 1'b1; seq_phase = tsm_pkg::PH_ST1;
				end
				tsm_pkg::PH_ST1: begin
					dat_q = 1'b0; seq_phase = tsm_pkg::PH_ST2;
				end
				tsm_pkg::PH_ST2: begin
					sck_q = 1'b0; seq_phase = tsm_pkg::PH_ST3;
				end
				tsm_pkg::PH_ST3: begin
					sck_q = 1'b1; seq_phase = tsm_pkg::PH_ST4;
				end
				tsm_pkg::PH_ST4: begin
					dat_q = 1'b1;
					if (op_q == tsm_pkg::OP_CONN_RST) begin
						finish_op(16'h0000, 1'b0);
					end else begin
						shift_q = cmd_q; bit_idx = '0; stage_q = 1'b0;
						seq_phase = tsm_pkg::PH_TX_LOW;
					end
				end
				tsm_pkg::PH_TX_LOW: begin
					sck_q = 1'b0; seq_phase = tsm_pkg::PH_TX_DATA;
				end
				tsm_pkg::PH_TX_DATA: begin
					sck_q     = 1'b0;
					dat_q     = shift_q[7];
					shift_q   = {shift_q[6:0], 1'b0};
					seq_phase = tsm_pkg::PH_TX_CLK;
				end
				tsm_pkg::PH_TX_CLK: begin
					sck_q   = 1'b1;
					bit_idx = bit_idx + 4'd1;
					if (bit_idx >= tsm_pkg::BYTE_BITS) begin
						bit_idx = '0; seq_phase = tsm_pkg::PH_ACK_REL;
					end else begin
						seq_phase = tsm_pkg::PH_TX_DATA;
					end
				end
				tsm_pkg::PH_ACK_REL: begin
					sck_q = 1'b0; dat_q = 1'b1; poll_cnt = '0;
					seq_phase = tsm_pkg::PH_ACK_POLL;
				end
				tsm_pkg::PH_ACK_POLL: begin
					sck_q = 1'b1; dat_q = 1'b1;
					if (!r.data_pin) begin
						seq_phase = tsm_pkg::PH_ACK_END;
					end else if (poll_cnt == timeout_lim) begin
						finish_op((op_q == tsm_pkg::OP_READ_SR) ?
							tsm_pkg::READ_FAIL_VAL : 16'h0000, 1'b1);
					end else begin
						poll_cnt = poll_cnt + 16'd1;
					end
				end
				tsm_pkg::PH_ACK_END: begin
					sck_q = 1'b0; dat_q = 1'b1;
					if (op_q == tsm_pkg::OP_MEASURE) begin
						total    = 24'(wait_q) * 24'(ticks_ms);
						poll_cnt = '0;
						if (total == '0) begin
							seq_phase = tsm_pkg::PH_READY;
						end else begin
							wait_cnt = total; seq_phase = tsm_pkg::PH_WAIT;
						end
					end else if (op_q == tsm_pkg::OP_READ_SR) begin
						stage_q = 1'b0; bit_idx = '0; seq_phase = tsm_pkg::PH_RX_LOW;
					end else if (op_q == tsm_pkg::OP_WRITE_SR && !stage_q) begin
						stage_q = 1'b1; shift_q = wr_q; bit_idx = '0;
						seq_phase = tsm_pkg::PH_TX_LOW;
					end else begin
						finish_op(16'h0000, 1'b0);
					end
				end
				tsm_pkg::PH_WAIT: begin
					wait_cnt = wait_cnt - 24'd1;
					if (wait_cnt == '0) begin
						poll_cnt = '0; seq_phase = tsm_pkg::PH_READY;
					end
				end
				tsm_pkg::PH_READY: begin
					if (!r.data_pin) begin
						bit_idx = '0; stage_q = 1'b0; seq_phase = tsm_pkg::PH_RX_LOW;
					end else if (poll_cnt == timeout_lim) begin
						finish_op(16'h0000, 1'b1);
					end else begin
						poll_cnt = poll_cnt + 16'd1;
					end
				end
				tsm_pkg::PH_RX_LOW: begin
					sck_q = 1'b0; dat_q = 1'b1; seq_phase = tsm_pkg::PH_RX_HI;
				end
				tsm_pkg::PH_RX_HI: begin
					sck_q     = 1'b1;
					shift_q   = {shift_q[6:0], r.data_pin};
					seq_phase = tsm_pkg::PH_RX_FALL;
				end
				tsm_pkg::PH_RX_FALL: begin
					sck_q   = 1'b0;
					bit_idx = bit_idx + 4'd1;
					if (bit_idx < tsm_pkg::BYTE_BITS) begin
						seq_phase = tsm_pkg::PH_RX_HI;
					end else begin
						bit_idx = '0;
						if (op_q == tsm_pkg::OP_MEASURE && !stage_q) begin
							hi_byte = shift_q; stage_q = 1'b1; seq_phase = tsm_pkg::PH_MA0;
						end else begin
							seq_phase = tsm_pkg::PH_END0;
						end
					end
				end
				tsm_pkg::PH_MA0: begin
					sck_q = 1'b0; seq_phase = tsm_pkg::PH_MA1;
				end
				tsm_pkg::PH_MA1: begin
					dat_q = 1'b0; seq_phase = tsm_pkg::PH_MA2;
				end
				tsm_pkg::PH_MA2: begin
					sck_q = 1'b1; seq_phase = tsm_pkg::PH_MA3;
				end
				tsm_pkg::PH_MA3: begin
					sck_q = 1'b0; seq_phase = tsm_pkg::PH_RX_LOW;
				end
				tsm_pkg::PH_END0: begin
					dat_q = 1'b1; sck_q = 1'b1; seq_phase = tsm_pkg::PH_END1;
				end
				tsm_pkg::PH_END1: begin
					sck_q = 1'b0;
					if (op_q == tsm_pkg::OP_MEASURE) finish_op({hi_byte, shift_q}, 1'b0);
					else finish_op({8'h00, shift_q}, 1'b0);
				end
				default: begin
					seq_phase = tsm_pkg::PH_IDLE;
				end
			endcase
		end
		res.sck          = sck_q;
		res.data_release = dat_q;
		res.busy_res     = (seq_phase != tsm_pkg::PH_IDLE);
		res.done_res     = done_q;
		res.result_value = held_val;
		res.status       = held_st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// return the prediction to its reset state
			seq_phase   = tsm_pkg::PH_IDLE;
			bit_idx     = '0;
			shift_q     = '0;
			poll_cnt    = '0;
			wait_cnt    = '0;
			hi_byte     = '0;
			op_q        = tsm_pkg::OP_MEASURE;
			cmd_q       = '0;
			wr_q        = '0;
			wait_q      = '0;
			stage_q     = 1'b0;
			sck_q       = 1'b0;
			dat_q       = 1'b1;
			done_q      = 1'b0;
			held_st     = 1'b0;
			held_val    = '0;
			timeout_lim = tsm_pkg::TIMEOUT_RESET;
			ticks_ms    = tsm_pkg::TICKS_PER_MS_RESET;
			pin_results_q.delete();
			pending     = 0;
			fail_count  = 0;
		end else begin
			// compare a taken result with the oldest prediction
			if (out_valid && out_ready) begin
				if (pin_results_q.size() == 0) begin
					flag_mismatch("result with no request waiting", result_value, 0);
				end else begin
					want             = pin_results_q.pop_front();
					got.sck          = sck;
					got.data_release = data_release;
					got.busy_res     = busy_res;
					got.done_res     = done_res;
					got.result_value = result_value;
					got.status       = status;
					if (got.sck != want.sck)
						flag_mismatch("sck", got.sck, want.sck);
					if (got.data_release != want.data_release)
						flag_mismatch("data_release", got.data_release, want.data_release);
					if (got.busy_res != want.busy_res)
						flag_mismatch("busy_res", got.busy_res, want.busy_res);
					if (got.done_res != want.done_res)
						flag_mismatch("done_res", got.done_res, want.done_res);
					if (got.result_value != want.result_value)
						flag_mismatch("result_value", got.result_value, want.result_value);
					if (got.status != want.status)
						flag_mismatch("status", got.status, want.status);
				end
			end
			// track register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tsm_pkg::REG_TIMEOUT) timeout_lim = cfg_data;
				else ticks_ms = cfg_data;
			end
			// predict the result of a taken request
			if (in_valid && in_ready) begin
				req.kind         = kind;
				req.operation    = tsm_pkg::op_t'(operation);
				req.command_byte = command_byte;
				req.write_byte   = write_byte;
				req.wait_time    = wait_time;
				req.data_pin     = data_pin;
				advance_sequencer(req, want);
				pin_results_q.push_back(want);
			end
			pending = pin_results_q.size();
		end
	end

endmodule

// ----- tb/tb_two_wire_sensor_master.sv -----
// Testbench top for the two-wire sensor master: clock, reset, requests and verdict.
module tb_two_wire_sensor_master;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic        kind         = tsm_pkg::KIND_TICK;
	logic [1:0]  operation    = '0;
	logic [7:0]  command_byte = '0;
	logic [7:0]  write_byte   = '0;
	logic [7:0]  wait_time    = '0;
	logic        data_pin     = 1'b1;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic        sck;
	logic        data_release;
	logic        busy_res;
	logic        done_res;
	logic [15:0] result_value;
	logic        status;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic        cfg_index    = tsm_pkg::REG_TIMEOUT;
	logic [15:0] cfg_data     = '0;
	int          fail_count;
	int          pending;

	// Handshake history and run statistics
	logic        in_taken;
	logic        cfg_taken;
	int unsigned done_seen;
	int unsigned timeouts_seen;
	int unsigned requests      = 0;
	int unsigned settings      = 1;
	int unsigned burst_left    = 0;
	int unsigned gap_max       = 3;
	int unsigned cur_timeout   = tsm_pkg::TIMEOUT_RESET;
	int unsigned cur_tpm       = tsm_pkg::TICKS_PER_MS_RESET;

	// Receiver pattern state
	int unsigned stall_left    = 0;
	logic [31:0] stall_bits    = '1;

	two_wire_sensor_master i_dut (.*);

	sensor_master_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Remember what the last edge accepted and count finished operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken      <= 1'b0;
			cfg_taken     <= 1'b0;
			done_seen     <= 0;
			timeouts_seen <= 0;
		end else begin
			in_taken  <= in_valid && in_ready;
			cfg_taken <= cfg_valid && cfg_ready;
			if (out_valid && out_ready && done_res) begin
				done_seen <= done_seen + 1;
				if (status) timeouts_seen <= timeouts_seen + 1;
			end
		end
	end

	// Stall the result side on a random pattern, redrawn when its counter runs out
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = 64;
			case ($urandom_range(3))
				0: stall_bits = '1;
				1: stall_bits = $urandom;
				2: stall_bits = $urandom | $urandom;
				default: stall_bits = $urandom & $urandom;
			endcase
		end
		stall_left--;
		out_ready <= stall_bits[stall_left[4:0]];
	end

	// Offer one request and hold it until taken; called and returns at a falling edge
	task automatic send_request(input logic k, input logic [1:0] op, input logic [7:0] cmd,
			input logic [7:0] wr, input logic [7:0] wt, input logic pin);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
		in_valid     <= 1'b1;
		kind         <= k;
		operation    <= op;
		command_byte <= cmd;
		write_byte   <= wr;
		wait_time    <= wt;
		data_pin     <= pin;
		do @(negedge clk); while (!in_taken);
		requests++;
	endtask

	// Start one operation and feed ticks until its finish shows up on the result side
	task automatic run_operation(input tsm_pkg::op_t op, input logic [7:0] cmd,
			input logic [7:0] wr, input logic [7:0] wt, input int unsigned low_pct);
		int unsigned base;
		int unsigned n;
		logic pin;
		base = done_seen;
		n    = 0;
		send_request(tsm_pkg::KIND_START, op, cmd, wr, wt, 1'($urandom));
		while (done_seen == base && n < 300000) begin
			pin = ($urandom_range(99) >= low_pct);
			if (n < 8 && $urandom_range(29) == 0) begin
				// drop a start in while busy, the block must ignore it
				send_request(tsm_pkg::KIND_START, 2'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), pin);
			end else begin
				send_request(tsm_pkg::KIND_TICK, 2'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), pin);
			end
			n++;
		end
	endtask

	// Write one register and lower the channel for a cycle
	task automatic write_register(input logic idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold off until every predicted result has been taken, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Move to a new register setting while the block is idle
	task automatic set_phase(input logic [15:0] timeout_val, input logic [15:0] tpm_val);
		drain();
		write_register(tsm_pkg::REG_TIMEOUT, timeout_val);
		write_register(tsm_pkg::REG_TICKS_PER_MS, tpm_val);
		cur_timeout = timeout_val;
		cur_tpm     = tpm_val;
		settings++;
	endtask

	// One random operation, with the wait bounded so the run stays short
	task automatic random_operation();
		tsm_pkg::op_t op;
		int unsigned wt_max;
		int unsigned pct;
		logic [7:0] wt;
		op = tsm_pkg::op_t'($urandom_range(3));
		if ($urandom_range(1)) op = tsm_pkg::OP_MEASURE;
		wt_max = 16 / cur_tpm;
		if (wt_max > 255) wt_max = 255;
		wt = (op == tsm_pkg::OP_MEASURE) ? 8'($urandom_range(wt_max)) : 8'($urandom);
		case ($urandom_range(4))
			0: pct = 0;
			1: pct = 20;
			2: pct = 50;
			3: pct = 80;
			default: pct = 100;
		endcase
		if (cur_timeout > 64 && pct == 0) pct = 50;
		run_operation(op, 8'($urandom), 8'($urandom), wt, pct);
		// send a few idle ticks now and then
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(3, 1))
				send_request(tsm_pkg::KIND_TICK, 2'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [15:0] tmo;
		logic [15:0] tpm;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: connection reset, then a measure with zero wait and data held low
		run_operation(tsm_pkg::OP_CONN_RST, 8'h00, 8'h00, 8'h00, 50);
		run_operation(tsm_pkg::OP_MEASURE, 8'h03, 8'h00, 8'h00, 100);

		// shortest timeout: ack timeouts on a measure and a status read
		set_phase(16'd0, 16'd1);
		run_operation(tsm_pkg::OP_MEASURE, 8'h03, 8'h00, 8'h00, 0);
		run_operation(tsm_pkg::OP_READ_SR, 8'h07, 8'h00, 8'h00, 0);

		// largest settings: zero wait measure and a status write
		set_phase(16'hffff, 16'hffff);
		run_operation(tsm_pkg::OP_MEASURE, 8'h05, 8'h00, 8'h00, 100);
		run_operation(tsm_pkg::OP_WRITE_SR, 8'h06, 8'h5a, 8'h00, 60);

		// random settings and operations until the request budget is spent
		while (requests < 400) begin
			case ($urandom_range(3))
				0: tmo = 16'd0;
				1: tmo = 16'($urandom_range(12, 1));
				2: tmo = 16'hffff;
				default: tmo = 16'($urandom);
			endcase
			tpm = ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 600))
				: 16'($urandom_range(4, 1));
			set_phase(tmo, tpm);
			gap_max = $urandom_range(1) ? 0 : 5;
			repeat (2) random_operation();
		end

		drain();
		repeat (8) @(negedge clk);
		$display("run covered %0d requests and %0d finished operations, %0d of them timed out",
			requests, done_seen, timeouts_seen);
		$display("over %0d register settings with %0d mismatches", settings, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// End a hung run
	initial begin : watchdog
		#1ms;
		$display("simulation failed");
		$finish;
	end

endmodule
